/* rtl/core/ghp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants for the generational handle pool.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned GEN_BITS   = 16;
  localparam int unsigned CAP_BITS   = 9;
  localparam int unsigned CAPW       = 17;   // wide enough for any slot count
  localparam logic [31:0] NULL_HANDLE = 32'd0;

  // request opcodes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    K_CREATE,
    K_LOOKUP,
    K_DESTROY,
    K_REJECT
  } cmd_kind_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] health;
  } payload_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        handle_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] health_in;
  } pool_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        handle_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] health_out;
    logic [8:0]         live_count;
  } pool_res_t;

  // classified request, front to back
  typedef struct packed {
    cmd_kind_t              kind;
    logic [INDEX_BITS-1:0]  idx;
    logic [GEN_BITS-1:0]    gen;
    payload_t               data;
  } pool_cmd_t;

  // back-end status seen by the front
  typedef struct packed {
    logic            clearing;
    logic [CAPW-1:0] cap;
  } pool_ctl_t;

  typedef struct packed {
    logic                live;
    logic [GEN_BITS-1:0] gen;
  } slot_meta_t;

endpackage

/* rtl/core/ghp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ghp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ghp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ghp_pkg::pool_req_t req,
  input  ghp_pkg::pool_ctl_t ctl,
  output logic              q_valid,
  output ghp_pkg::pool_cmd_t q_head,
  input  logic              q_pop
);
  import ghp_pkg::*;

  pool_cmd_t             slots [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  pool_cmd_t             cmd;
  logic [INDEX_BITS-1:0] idx16;
  logic                  in_range;
  logic                  do_push;
  logic                  do_pop;

  // classify: decode opcode and range-check the handle index
  always_comb begin
    idx16    = req.handle_in[INDEX_BITS-1:0] - INDEX_BITS'(1);
    in_range = (CAPW'(idx16) < ctl.cap) && (req.handle_in != NULL_HANDLE);
    cmd.idx  = idx16;
    cmd.gen  = req.handle_in[31:INDEX_BITS];
    cmd.data = '{pos_x: req.pos_x_in, pos_y: req.pos_y_in, health: req.health_in};
    unique case (req.op)
      OP_CREATE:  cmd.kind = K_CREATE;
      OP_LOOKUP:  cmd.kind = in_range ? K_LOOKUP : K_REJECT;
      OP_DESTROY: cmd.kind = in_range ? K_DESTROY : K_REJECT;
      default:    cmd.kind = K_REJECT;
    endcase
  end

  assign full    = (count == 2'd2) || ctl.clearing;
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_head  = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* rtl/core/ghp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_back
// Executes classified requests against the slot and free-stack memories.
// ----------------------------------------------------------------------------
module ghp_back #(
  parameter int unsigned SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  input  logic              q_valid,
  input  ghp_pkg::pool_cmd_t q_head,
  output logic              q_pop,
  output ghp_pkg::pool_ctl_t ctl,
  output logic              empty,
  input  logic              pop,
  output ghp_pkg::pool_res_t res
);
  import ghp_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FL_WAIT,
    S_META_WAIT
  } state_t;

  state_t            state;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     free_count;
  logic [IW-1:0]     clr_idx;
  cmd_kind_t         cur_kind;
  logic [IW-1:0]     cur_idx;
  logic [GEN_BITS-1:0] cur_gen;
  payload_t          cur_data;
  logic              out_valid;
  pool_res_t         out_res;

  logic              meta_we;
  logic [IW-1:0]     meta_waddr;
  slot_meta_t        meta_wdata;
  logic [IW-1:0]     meta_raddr;
  slot_meta_t        meta_rdata;
  logic              pay_we;
  logic [IW-1:0]     pay_waddr;
  payload_t          pay_rdata;
  logic              fl_we;
  logic [IW-1:0]     fl_waddr;
  logic [IW-1:0]     fl_wdata;
  logic [IW-1:0]     fl_raddr;
  logic [IW-1:0]     fl_rdata;

  logic              out_free;
  logic              start;
  logic              clr_last;
  logic              hit;
  logic              can_free;
  logic [CAPW-1:0]   cap_wr;

  // clamp a written capacity into 1..SLOTS
  always_comb begin
    cap_wr = CAPW'(cfg_wdata);
    if (cap_wr == '0) begin
      cap_wr = CAPW'(1);
    end else if (cap_wr > CAPW'(SLOTS)) begin
      cap_wr = CAPW'(SLOTS);
    end
  end

  assign out_free = !out_valid || pop;
  assign start    = (state == S_IDLE) && q_valid && out_free;
  assign q_pop    = start;
  assign clr_last = (CAPW'(clr_idx) == CAPW'(cap) - CAPW'(1));
  assign hit      = meta_rdata.live && (meta_rdata.gen == cur_gen);
  assign can_free = (free_count < cap);
  assign ctl      = '{clearing: (state == S_CLEAR), cap: CAPW'(cap)};
  assign empty    = !out_valid;
  assign res      = out_res;

  // memory port control
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cur_idx;
    meta_wdata = '{live: 1'b0, gen: '0};
    meta_raddr = q_head.idx[IW-1:0];
    pay_we     = 1'b0;
    pay_waddr  = fl_rdata;
    fl_we      = 1'b0;
    fl_waddr   = free_count[IW-1:0];
    fl_wdata   = cur_idx;
    fl_raddr   = IW'(free_count - CW'(1));
    unique case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        fl_we      = 1'b1;
        fl_waddr   = clr_idx;
        fl_wdata   = IW'(cap - CW'(1) - CW'(clr_idx));
      end
      S_IDLE: begin
      end
      S_FL_WAIT: begin
        // popped index: fetch its generation, store the payload
        meta_raddr = fl_rdata;
        pay_we     = 1'b1;
      end
      S_META_WAIT: begin
        case (cur_kind)
          K_CREATE: begin
            meta_we    = 1'b1;
            meta_wdata = '{live: 1'b1, gen: meta_rdata.gen};
          end
          K_DESTROY: begin
            if (hit && can_free) begin
              meta_we    = 1'b1;
              meta_wdata = '{live: 1'b0, gen: meta_rdata.gen + GEN_BITS'(1)};
              fl_we      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cap        <= CW'(SLOTS < 256 ? SLOTS : 256);
      free_count <= CW'(SLOTS < 256 ? SLOTS : 256);
      clr_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur_kind <= q_head.kind;
            cur_idx  <= q_head.idx[IW-1:0];
            cur_gen  <= q_head.gen;
            cur_data <= q_head.data;
            out_res  <= '{status: ST_INVALID, handle_out: '0, pos_x_out: '0,
                          pos_y_out: '0, health_out: '0,
                          live_count: 9'(cap - free_count)};
            case (q_head.kind)
              K_CREATE: begin
                if (free_count == '0) begin
                  out_res.status <= ST_FULL;
                  out_valid      <= 1'b1;
                end else begin
                  state <= S_FL_WAIT;
                end
              end
              K_LOOKUP, K_DESTROY: state <= S_META_WAIT;
              default:             out_valid <= 1'b1;
            endcase
          end
        end
        S_FL_WAIT: begin
          cur_idx    <= fl_rdata;
          free_count <= free_count - CW'(1);
          state      <= S_META_WAIT;
        end
        S_META_WAIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
          case (cur_kind)
            K_CREATE: begin
              out_res.status     <= ST_OK;
              out_res.handle_out <= {meta_rdata.gen, INDEX_BITS'(cur_idx) + INDEX_BITS'(1)};
              out_res.live_count <= 9'(cap - free_count);
            end
            K_LOOKUP: begin
              if (hit) begin
                out_res.status     <= ST_OK;
                out_res.pos_x_out  <= pay_rdata.pos_x;
                out_res.pos_y_out  <= pay_rdata.pos_y;
                out_res.health_out <= pay_rdata.health;
              end
            end
            K_DESTROY: begin
              if (hit && can_free) begin
                out_res.status     <= ST_OK;
                out_res.live_count <= 9'(cap - free_count - CW'(1));
                free_count         <= free_count + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
      // capacity write restarts the pool
      if (cfg_we) begin
        cap        <= CW'(cap_wr);
        free_count <= CW'(cap_wr);
        clr_idx    <= '0;
        state      <= S_CLEAR;
      end
    end
  end

  ghp_ram #(.WIDTH(GEN_BITS + 1), .DEPTH(SLOTS)) u_meta (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .raddr(meta_raddr),
    .rdata(meta_rdata)
  );

  ghp_ram #(.WIDTH($bits(payload_t)), .DEPTH(SLOTS)) u_pay (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(cur_data),
    .raddr(q_head.idx[IW-1:0]),
    .rdata(pay_rdata)
  );

  ghp_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_free (
    .clk  (clk),
    .we   (fl_we),
    .waddr(fl_waddr),
    .wdata(fl_wdata),
    .raddr(fl_raddr),
    .rdata(fl_rdata)
  );

endmodule

/* rtl/core/generational_handle_pool_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_pool_unit
// Slot table addressed through generation-tagged 32-bit handles.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and results leave
// through another (empty/pop), oldest first, one result per request.
// A request is classified on entry and parked in a two-entry queue; the
// execution side takes it when it is idle and the result register is free,
// in the cycle after acceptance at the earliest.
// In the execution side, a rejected request, or a create on a full pool,
// is answered straight from the idle state; a lookup or destroy waits on
// the slot's metadata and payload reads; a create first reads the free
// stack, then the slot's generation, each through a registered memory port.
// Requests run one at a time: a new one starts only after the last is done.
// Results hold in the output register while pop is low; the input queue
// keeps taking requests until it fills, then full rises.
// Reset, and every capacity write, starts a clearing pass over the first
// cap slots (cap = clamped capacity, min(SLOTS, 256) after reset) that
// zeroes the slot metadata and refills the free stack; full is high meanwhile.
// The user must write capacity only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module generational_handle_pool_unit #(
  parameter int unsigned SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ghp_pkg::pool_req_t req,
  output logic               empty,
  input  logic               pop,
  output ghp_pkg::pool_res_t res,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata
);
  import ghp_pkg::*;

  pool_ctl_t ctl;
  pool_cmd_t q_head;
  logic      q_valid;
  logic      q_pop;

  ghp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req    (req),
    .ctl    (ctl),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  ghp_back #(.SLOTS(SLOTS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .ctl      (ctl),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

endmodule

/* tb/tb_generational_handle_pool_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_pool_unit
// Self-checking bench for the generational handle pool.
// ----------------------------------------------------------------------------
// A table of directed requests runs first: null and out-of-range handles, the
// unused opcode and stale handles; then a one-slot pool is filled until full.
// Random ones follow, mostly handed-out handles, some stale, some noise. Every
// request is predicted by a behavioral copy of the pool, and every result is
// compared field by field with the oldest prediction. The capacity register
// is written between phases, including its extremes and out-of-range values.
// ----------------------------------------------------------------------------
module tb_generational_handle_pool_unit;
  import ghp_pkg::*;

  localparam int NSLOT = 256;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  pool_req_t req = '0;
  logic      empty;
  logic      pop = 1'b0;
  pool_res_t res;
  logic      cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;

  generational_handle_pool_unit #(.SLOTS(NSLOT)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // behavioral pool
  int unsigned      pool_cap;
  logic [15:0]      pool_gen [NSLOT];
  logic             pool_live [NSLOT];
  payload_t         pool_data [NSLOT];
  logic [7:0]       free_slots [NSLOT];
  int unsigned      free_depth;

  pool_res_t        expected_q [$];
  logic [31:0]      issued_handles [$];
  int               mismatches = 0;
  bit               hold_results = 1'b0;

  function automatic void pool_reinit(input logic [8:0] count);
    int unsigned c;
    c = (count == 0) ? 1 : ((count > NSLOT) ? NSLOT : count);
    pool_cap = c;
    for (int i = 0; i < NSLOT; i++) begin
      pool_gen[i]   = '0;
      pool_live[i]  = 1'b0;
      pool_data[i]  = '0;
      free_slots[i] = '0;
    end
    for (int i = 0; i < c; i++) free_slots[i] = 8'(c - 1 - i);
    free_depth = c;
  endfunction

  function automatic bit handle_ok(input logic [31:0] h, output int unsigned slot);
    logic [15:0] i;
    i = h[15:0] - 16'd1;
    slot = 32'(i);
    if (h == NULL_HANDLE) return 0;
    if (i >= pool_cap) return 0;
    if (!pool_live[i]) return 0;
    return pool_gen[i] == h[31:16];
  endfunction

  function automatic pool_res_t pool_apply(input pool_req_t r);
    pool_res_t   o;
    int unsigned s;
    o = '0;
    o.status = ST_INVALID;
    case (r.op)
      OP_CREATE: begin
        if (free_depth == 0) o.status = ST_FULL;
        else begin
          free_depth--;
          s = 32'(free_slots[free_depth]);
          pool_data[s] = '{r.pos_x_in, r.pos_y_in, r.health_in};
          pool_live[s] = 1'b1;
          o.handle_out = {pool_gen[s], 16'(s + 1)};
          o.status = ST_OK;
          issued_handles.push_back(o.handle_out);
        end
      end
      OP_LOOKUP: begin
        if (handle_ok(r.handle_in, s)) begin
          o.pos_x_out  = pool_data[s].pos_x;
          o.pos_y_out  = pool_data[s].pos_y;
          o.health_out = pool_data[s].health;
          o.status = ST_OK;
        end
      end
      OP_DESTROY: begin
        if (handle_ok(r.handle_in, s) && free_depth < pool_cap) begin
          pool_live[s] = 1'b0;
          pool_gen[s]  = pool_gen[s] + 16'd1;
          free_slots[free_depth] = 8'(s);
          free_depth++;
          o.status = ST_OK;
        end
      end
      default: ;
    endcase
    o.live_count = 9'(pool_cap - free_depth);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result side: random pop gaps, long hold-off on request
  initial begin
    int gap;
    pool_res_t e;
    wait (!rst);
    forever begin
      gap = hold_results ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0 || hold_results) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (res.status !== e.status)
          report_mismatch("status", 32'(res.status), 32'(e.status));
        if (res.handle_out !== e.handle_out)
          report_mismatch("handle", res.handle_out, e.handle_out);
        if (res.pos_x_out !== e.pos_x_out) report_mismatch("pos_x", res.pos_x_out, e.pos_x_out);
        if (res.pos_y_out !== e.pos_y_out) report_mismatch("pos_y", res.pos_y_out, e.pos_y_out);
        if (res.health_out !== e.health_out)
          report_mismatch("health", res.health_out, e.health_out);
        if (res.live_count !== e.live_count)
          report_mismatch("live", 32'(res.live_count), 32'(e.live_count));
      end
    end
  end

  // offer one request; wait for acceptance, then predict
  // push stays high on return so the next request can follow at once
  task automatic send_request(input pool_req_t r, input bit idle_gaps);
    pool_res_t p;
    int gap;
    gap = idle_gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    p = pool_apply(r);
    expected_q.push_back(p);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_reinit(v);
    issued_handles.delete();
  endtask

  function automatic pool_req_t make_req(input logic [1:0] op, input logic [31:0] h);
    pool_req_t r;
    r.op = op;
    r.handle_in = h;
    r.pos_x_in  = $urandom;
    r.pos_y_in  = $urandom;
    r.health_in = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] pick_handle();
    int k;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {16'($urandom_range(0, 3)), 16'($urandom_range(0, 300))};
      default: begin
        if (issued_handles.size() == 0) return $urandom;
        k = $urandom_range(0, issued_handles.size() - 1);
        return issued_handles[k];
      end
    endcase
  endfunction

  // directed rows: op, handle, check status/live directly (check = 1)
  typedef struct {
    logic [1:0]  op;
    logic [31:0] handle;
    bit          check;
    logic [1:0]  status;
    logic [8:0]  live;
  } directed_row_t;

  directed_row_t directed_rows [] = '{
    '{OP_LOOKUP,  32'h0000_0000, 1, ST_INVALID, 9'd0},
    '{OP_DESTROY, 32'h0000_0001, 1, ST_INVALID, 9'd0},
    '{2'd3,       32'h0000_0001, 1, ST_INVALID, 9'd0},
    '{OP_CREATE,  32'h0,         1, ST_OK,      9'd1},
    '{OP_CREATE,  32'h0,         1, ST_OK,      9'd2},
    '{OP_LOOKUP,  32'h0000_0001, 1, ST_OK,      9'd2},
    '{OP_LOOKUP,  32'h0001_0001, 1, ST_INVALID, 9'd2},
    '{OP_LOOKUP,  32'hFFFF_0000, 1, ST_INVALID, 9'd2},
    '{OP_LOOKUP,  32'h0000_FFFF, 1, ST_INVALID, 9'd2},
    '{OP_LOOKUP,  32'h0000_0101, 1, ST_INVALID, 9'd2},
    '{OP_DESTROY, 32'h0000_0001, 1, ST_OK,      9'd1},
    '{OP_DESTROY, 32'h0000_0001, 1, ST_INVALID, 9'd1},
    '{OP_LOOKUP,  32'h0000_0001, 1, ST_INVALID, 9'd1},
    '{OP_CREATE,  32'h0,         0, ST_OK,      9'd0},
    '{OP_LOOKUP,  32'h0001_0001, 0, ST_OK,      9'd0},
    '{2'd3,       32'hFFFF_FFFF, 1, ST_INVALID, 9'd2},
    '{OP_DESTROY, 32'h0000_0002, 1, ST_OK,      9'd1},
    '{OP_DESTROY, 32'h0001_0001, 1, ST_OK,      9'd0}
  };

  initial begin
    pool_req_t r;
    pool_res_t p;
    logic [8:0] caps [] = '{9'd256, 9'd0, 9'd1, 9'd2, 9'd511, 9'd5, 9'd300, 9'd17};
    pool_reinit(9'd256);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      r = make_req(directed_rows[i].op, directed_rows[i].handle);
      if (i == 3) r = '{OP_CREATE, 32'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF};
      if (i == 4) r = '{OP_CREATE, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0};
      send_request(r, 1'b1);
      if (directed_rows[i].check) begin
        p = expected_q[$];
        if (p.status !== directed_rows[i].status || p.live_count !== directed_rows[i].live)
          report_mismatch("directed row", 32'(i), 32'({p.status, p.live_count}));
      end
    end

    // smallest pool: fill it and hit full
    write_capacity(9'd1);
    send_request(make_req(OP_CREATE, 32'h0), 1'b0);
    send_request(make_req(OP_CREATE, 32'h0), 1'b0);
    send_request(make_req(OP_DESTROY, 32'h0000_0002), 1'b0);
    send_request(make_req(OP_DESTROY, 32'h0000_0001), 1'b0);
    send_request(make_req(OP_LOOKUP, 32'h0001_0001), 1'b0);

    // backpressure: hold results while requests keep coming
    drain_results();
    hold_results = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_results = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_request(make_req(OP_CREATE, 32'h0), 1'b0);
    join

    // random phases over several capacities
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      for (int n = 0; n < 110; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r = make_req(OP_CREATE, $urandom);
          4, 5, 6:    r = make_req(OP_LOOKUP, pick_handle());
          7, 8:       r = make_req(OP_DESTROY, pick_handle());
          default:    r = make_req(2'd3, $urandom);
        endcase
        send_request(r, ($urandom_range(0, 4) != 0));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ghp_pkg.sv
rtl/core/ghp_ram.sv
rtl/core/ghp_front.sv
rtl/core/ghp_back.sv
rtl/core/generational_handle_pool_unit.sv
tb/tb_generational_handle_pool_unit.sv
